// File: sv/rddpt_pkg.sv
// Shared widths, register indexes and reset values of the random dot/dash pulse timer.
`timescale 1ns / 1ps

package rddpt_pkg;

  localparam int unsigned Channels   = 3;
  localparam int unsigned RandWidth  = 3;
  localparam int unsigned MaskWidth  = 3;
  localparam int unsigned CountWidth = 4;
  localparam int unsigned DotWidth   = 3;
  localparam int unsigned DashWidth  = 4;
  localparam int unsigned PauseWidth = 3;
  localparam int unsigned TdataWidth = 8;
  localparam int unsigned CfgIdxWidth  = 2;
  localparam int unsigned CfgDataWidth = 4;

  localparam logic [CfgIdxWidth-1:0] RegDotTicks   = 2'd0;
  localparam logic [CfgIdxWidth-1:0] RegDashTicks  = 2'd1;
  localparam logic [CfgIdxWidth-1:0] RegPauseTicks = 2'd2;

  localparam logic [DotWidth-1:0]   DotTicksRst   = 3'd1;
  localparam logic [DashWidth-1:0]  DashTicksRst  = 4'd3;
  localparam logic [PauseWidth-1:0] PauseTicksRst = 3'd1;

endpackage

// File: sv/random_dot_dash_pulse_timer.sv
// Random dot/dash pulse timer: per-channel pulse/pause sequencing with a skid-buffered output.
//
// Usage:
//   Each transfer on the slave stream (s_axis_*) is one timer tick; tdata[2:0] carries one
//   random bit per channel (1 picks a dash for the next pulse). Every tick yields exactly
//   one transfer on the master stream (m_axis_*): tdata[2:0] shows which channels were in
//   their pulse phase before that tick advanced them.
//   Results reach m_axis through the output register, or via the skid register if held.
//   Throughput: one tick per cycle unless m_axis stalls; all channel counters advance
//   in parallel in the same cycle the tick is taken, so only the output registers bound it.
//   Stall: if m_axis_tready_i is low, one more tick is taken into a skid register; after
//   that s_axis_tready_o drops until the receiver drains a result.
//   Reset (rst_ni low): all channels start in pulse phase with dot length and a zero count,
//   both output registers empty, and the length registers at dot 1, dash 3, pause 1.
//   Configuration: cfg_we_i writes cfg_data_i to the register at cfg_index_i
//   (0 dot, 1 dash, 2 pause); write only while no tick is in flight.
`timescale 1ns / 1ps

module random_dot_dash_pulse_timer #(
  parameter int unsigned CHANNELS = rddpt_pkg::Channels
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // tdata: [2:0] random_bits, [7:3] zero
  input  logic [rddpt_pkg::TdataWidth-1:0]    s_axis_tdata_i,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // tdata: [2:0] active_mask, [7:3] zero
  output logic [rddpt_pkg::TdataWidth-1:0]    m_axis_tdata_o,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  input  logic                                cfg_we_i,
  input  logic [rddpt_pkg::CfgIdxWidth-1:0]   cfg_index_i,
  input  logic [rddpt_pkg::CfgDataWidth-1:0]  cfg_data_i
);

  localparam int unsigned ExtWidth =
    (CHANNELS > rddpt_pkg::RandWidth) ? CHANNELS : rddpt_pkg::RandWidth;
  localparam int unsigned CntW = rddpt_pkg::CountWidth;

  // Length registers
  logic [rddpt_pkg::DotWidth-1:0]   dot_ticks_q;
  logic [rddpt_pkg::DashWidth-1:0]  dash_ticks_q;
  logic [rddpt_pkg::PauseWidth-1:0] pause_ticks_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dot_ticks_q   <= rddpt_pkg::DotTicksRst;
      dash_ticks_q  <= rddpt_pkg::DashTicksRst;
      pause_ticks_q <= rddpt_pkg::PauseTicksRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        rddpt_pkg::RegDotTicks:   dot_ticks_q   <= cfg_data_i[rddpt_pkg::DotWidth-1:0];
        rddpt_pkg::RegDashTicks:  dash_ticks_q  <= cfg_data_i[rddpt_pkg::DashWidth-1:0];
        rddpt_pkg::RegPauseTicks: pause_ticks_q <= cfg_data_i[rddpt_pkg::PauseWidth-1:0];
        default: ;
      endcase
    end
  end

  // Handshake
  logic s_fire, m_fire;
  logic out_valid_q, skid_valid_q;
  logic [rddpt_pkg::MaskWidth-1:0] out_mask_q, skid_mask_q;

  assign s_axis_tready_o = !skid_valid_q;
  assign s_fire = s_axis_tvalid_i && s_axis_tready_o;
  assign m_fire = out_valid_q && m_axis_tready_i;

  // Channel state
  logic [CHANNELS-1:0] in_pause_q, in_pause_d;
  logic [CHANNELS-1:0] long_pulse_q, long_pulse_d;
  logic [CntW-1:0]     count_q [CHANNELS];
  logic [CntW-1:0]     count_d [CHANNELS];

  logic [ExtWidth-1:0] rbits;
  logic [ExtWidth-1:0] active_ext;
  logic [rddpt_pkg::MaskWidth-1:0] result_mask;

  // Channels past the input field width see a zero random bit
  assign rbits       = ExtWidth'(s_axis_tdata_i[rddpt_pkg::RandWidth-1:0]);
  assign active_ext  = ExtWidth'(~in_pause_q);
  assign result_mask = active_ext[rddpt_pkg::MaskWidth-1:0];

  always_comb begin
    logic [CntW-1:0] next_cnt;
    logic [CntW-1:0] pulse_len;
    for (int n = 0; n < CHANNELS; n++) begin
      next_cnt  = count_q[n] + CntW'(1);
      pulse_len = long_pulse_q[n] ? CntW'(dash_ticks_q) : CntW'(dot_ticks_q);
      in_pause_d[n]   = in_pause_q[n];
      long_pulse_d[n] = long_pulse_q[n];
      count_d[n]      = next_cnt;
      if (in_pause_q[n]) begin
        // Equality only: a zero pause wraps the counter round once
        if (next_cnt == CntW'(pause_ticks_q)) begin
          in_pause_d[n]   = 1'b0;
          long_pulse_d[n] = rbits[n];
          count_d[n]      = '0;
        end
      end else if (next_cnt >= pulse_len) begin
        in_pause_d[n] = 1'b1;
        count_d[n]    = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_pause_q   <= '0;
      long_pulse_q <= '0;
      for (int n = 0; n < CHANNELS; n++) begin
        count_q[n] <= '0;
      end
    end else if (s_fire) begin
      in_pause_q   <= in_pause_d;
      long_pulse_q <= long_pulse_d;
      for (int n = 0; n < CHANNELS; n++) begin
        count_q[n] <= count_d[n];
      end
    end
  end

  // Output register with one skid entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (m_fire || !out_valid_q) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= s_fire;
      end
    end else if (s_fire) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (m_fire || !out_valid_q) begin
      out_mask_q <= skid_valid_q ? skid_mask_q : result_mask;
    end else if (s_fire) begin
      skid_mask_q <= result_mask;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = rddpt_pkg::TdataWidth'(out_mask_q);

`ifndef SYNTHESIS
  // The skid entry is only filled behind a held result
  assert property (@(posedge clk_i) disable iff (!rst_ni) skid_valid_q |-> out_valid_q)
    else $error("skid entry valid without a held result");

  // Every accepted tick leaves a result pending in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni) s_fire |=> out_valid_q)
    else $error("accepted tick produced no result");

  // A tick is never taken while both output entries are full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && skid_valid_q) |-> !s_fire)
    else $error("tick accepted with full output stage");
`endif

endmodule
